>>> src/lrt_pkg.sv
// Shared types and constants for the lazy range add min/max tree.
package lrt_pkg;

  localparam int unsigned IndexBitsDefault = 10;
  localparam int unsigned ValBits = 48;
  localparam int unsigned DeltaBits = 32;
  localparam int unsigned CfgAddrBits = 3;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpMin = 2'd1;
  localparam logic [1:0] OpMax = 2'd2;
  localparam logic [1:0] OpSpread = 2'd3;

  localparam logic [CfgAddrBits-1:0] RegLastIndex = 3'd0;

  localparam logic signed [ValBits-1:0] VMax = {1'b0, {(ValBits-1){1'b1}}};
  localparam logic signed [ValBits-1:0] VMin = {1'b1, {(ValBits-1){1'b0}}};

  typedef logic signed [ValBits-1:0] val_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [ValBits:0] s;
    s = {a[ValBits-1], a} + {b[ValBits-1], b};
    if (s[ValBits] != s[ValBits-1]) begin
      sat_add = s[ValBits] ? VMin : VMax;
    end else begin
      sat_add = s[ValBits-1:0];
    end
  endfunction

endpackage

>>> src/lrt_node_mem.sv
// Node storage: min, max and pending add words with one registered read port.
module lrt_node_mem #(
  parameter int unsigned NodeBits = 11
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [NodeBits-1:0]   waddr_i,
  input  lrt_pkg::val_t         wmin_i,
  input  lrt_pkg::val_t         wmax_i,
  input  lrt_pkg::val_t         wpend_i,
  input  logic [NodeBits-1:0]   raddr_i,
  output lrt_pkg::val_t         rmin_o,
  output lrt_pkg::val_t         rmax_o,
  output lrt_pkg::val_t         rpend_o
);
  import lrt_pkg::*;
  localparam int unsigned Depth = 1 << NodeBits;

  val_t mem_min [Depth];
  val_t mem_max [Depth];
  val_t mem_pend [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_min[waddr_i] <= wmin_i;
      mem_max[waddr_i] <= wmax_i;
      mem_pend[waddr_i] <= wpend_i;
    end
    rmin_o <= mem_min[raddr_i];
    rmax_o <= mem_max[raddr_i];
    rpend_o <= mem_pend[raddr_i];
  end
endmodule

>>> src/lazy_range_add_min_max_tree.sv
// Top level: lazy segment tree with range add and range min/max/spread query.
// Usage: an item arrives on the s_axis channel; tdata holds operation,
// range_start, range_end and delta. Queries give one transfer on m_axis with
// answer and empty_range; range adds give none. The user must have the APB
// port write last_index (register 0) only while the block is idle (unchecked).
// The block handles one item at a time: s_axis_tready is low from accept
// until the item is finished and its result, if any, is taken.
// Node words sit in one memory with one registered read port and one write
// port, and a sequencer walks the tree on an explicit stack. A fully covered
// node is read and then updated or folded into the answer; a partly covered
// node also pushes its pending add to both children, and a range add later
// revisits each partly covered node to recombine its min and max.
// An empty add frees the input on the next cycle; an empty query goes straight
// to the output state, which registers its result with empty_range set.
// After reset a clearing pass zeroes all 2^(INDEX_BITS+1) node entries, one
// per cycle, with s_axis_tready low; last_index resets to 1023.
// When m_axis_tready is low, the result is held in its register and no new
// item is accepted.
module lazy_range_add_min_max_tree #(
  parameter int unsigned INDEX_BITS = lrt_pkg::IndexBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // {delta[31:0], range_end, range_start, operation[1:0]} from bit 0, zero fill
  input  logic [((2*INDEX_BITS+34+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // answer[47:0] from bit 0
  output logic [47:0]                   m_axis_tdata,
  // empty_range
  output logic                          m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrt_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lrt_pkg::*;

  localparam int unsigned NB = INDEX_BITS + 1;
  localparam int unsigned SD = 2 * INDEX_BITS;
  localparam int unsigned SB = $clog2(SD + 1);
  localparam int unsigned SI = $clog2(SD);
  localparam logic [INDEX_BITS-1:0] IdxMax = {INDEX_BITS{1'b1}};

  typedef enum logic [8:0] {
    StClr   = 9'b000000001,
    StIdle  = 9'b000000010,
    StPop   = 9'b000000100,
    StRd    = 9'b000001000,
    StVisit = 9'b000010000,
    StLeft  = 9'b000100000,
    StRight = 9'b001000000,
    StComb  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  // Stack frame: node, span, and phase (0 enter, 1 combine).
  typedef struct packed {
    logic [NB-1:0]         node;
    logic [INDEX_BITS-1:0] lo;
    logic [INDEX_BITS-1:0] hi;
    logic                  comb;
  } frame_t;

  state_e state_q;
  logic [NB-1:0] clr_q;
  logic [INDEX_BITS-1:0] last_q;
  logic [1:0] op_q;
  logic [INDEX_BITS-1:0] s_q, e_q;
  val_t delta_q, mn_q, mx_q;
  logic emp_q;
  frame_t stk_q [SD];
  logic [SB-1:0] sp_q, sp_dec;
  frame_t cur_q;
  val_t npend_q, lmin_q, lmax_q;

  logic we;
  logic [NB-1:0] waddr, raddr;
  val_t wmin, wmax, wpend, rmin, rmax, rpend;

  lrt_node_mem #(.NodeBits(NB)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wmin_i(wmin), .wmax_i(wmax),
    .wpend_i(wpend), .raddr_i(raddr), .rmin_o(rmin), .rmax_o(rmax), .rpend_o(rpend)
  );

  logic [1:0] in_op;
  logic [INDEX_BITS-1:0] in_s, in_e, top, ce;
  logic [DeltaBits-1:0] in_d;
  assign in_op = s_axis_tdata[1:0];
  assign in_s = s_axis_tdata[2 +: INDEX_BITS];
  assign in_e = s_axis_tdata[2+INDEX_BITS +: INDEX_BITS];
  assign in_d = s_axis_tdata[2+2*INDEX_BITS +: DeltaBits];
  assign top = last_q;
  assign ce = (in_e > top) ? top : in_e;

  assign pready = 1'b1;
  assign prdata = (paddr == RegLastIndex) ? {{(32-INDEX_BITS){1'b0}}, last_q} : 32'd0;
  assign s_axis_tready = (state_q == StIdle) && !m_axis_tvalid;

  logic isleaf, kidleaf, full, go_l, go_r;
  logic [INDEX_BITS-1:0] mid;
  assign isleaf = cur_q.node[NB-1];
  assign kidleaf = cur_q.node[NB-2];
  assign full = (s_q <= cur_q.lo) && (cur_q.hi <= e_q);
  assign mid = cur_q.lo + ((cur_q.hi - cur_q.lo) >> 1);
  assign go_l = (s_q <= mid);
  assign go_r = (e_q > mid);
  assign sp_dec = sp_q - 1'b1;

  logic [NB-1:0] lch, rch;
  assign lch = {cur_q.node[NB-2:0], 1'b0};
  assign rch = {cur_q.node[NB-2:0], 1'b1};

  val_t spread;
  logic signed [ValBits:0] diff;
  assign diff = {mx_q[ValBits-1], mx_q} - {mn_q[ValBits-1], mn_q};
  assign spread = (diff[ValBits] != diff[ValBits-1]) ? VMax : diff[ValBits-1:0];

  always_comb begin
    we = 1'b0;
    waddr = cur_q.node;
    wmin = '0;
    wmax = '0;
    wpend = '0;
    raddr = cur_q.node;
    unique case (state_q)
      StClr: begin
        we = 1'b1;
        waddr = clr_q;
      end
      StRd: begin
        if (cur_q.comb) raddr = lch;
      end
      StVisit: begin
        if (cur_q.comb) begin
          raddr = rch;
        end else if (full) begin
          if (op_q == OpAdd) begin
            we = 1'b1;
            wmin = sat_add(rmin, delta_q);
            wmax = sat_add(rmax, delta_q);
            wpend = isleaf ? rpend : sat_add(rpend, delta_q);
          end
        end else begin
          we = 1'b1;
          wmin = rmin;
          wmax = rmax;
          raddr = lch;
        end
      end
      StLeft: begin
        we = 1'b1;
        waddr = lch;
        wmin = sat_add(rmin, npend_q);
        wmax = sat_add(rmax, npend_q);
        wpend = kidleaf ? rpend : sat_add(rpend, npend_q);
        raddr = rch;
      end
      StRight: begin
        we = 1'b1;
        waddr = rch;
        wmin = sat_add(rmin, npend_q);
        wmax = sat_add(rmax, npend_q);
        wpend = kidleaf ? rpend : sat_add(rpend, npend_q);
      end
      StComb: begin
        we = 1'b1;
        wmin = (lmin_q < rmin) ? lmin_q : rmin;
        wmax = (lmax_q > rmax) ? lmax_q : rmax;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q <= '0;
      last_q <= IdxMax;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
      op_q <= '0;
      s_q <= '0;
      e_q <= '0;
      delta_q <= '0;
      mn_q <= '0;
      mx_q <= '0;
      emp_q <= 1'b0;
      sp_q <= '0;
      cur_q <= '0;
      npend_q <= '0;
      lmin_q <= '0;
      lmax_q <= '0;
      for (int i = 0; i < SD; i++) stk_q[i] <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegLastIndex) begin
        last_q <= pwdata[INDEX_BITS-1:0];
      end
      if (state_q == StOut) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser <= emp_q;
        m_axis_tdata <= emp_q ? '0 : (op_q == OpMin) ? mn_q :
                        (op_q == OpMax) ? mx_q : spread;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op_q <= in_op;
            s_q <= in_s;
            e_q <= ce;
            delta_q <= {{(ValBits-DeltaBits){in_d[DeltaBits-1]}}, in_d};
            mn_q <= VMax;
            mx_q <= VMin;
            emp_q <= in_s > ce;
            sp_q <= '0;
            if (in_s > ce) begin
              state_q <= (in_op == OpAdd) ? StIdle : StOut;
            end else begin
              cur_q <= '{node: {{(NB-1){1'b0}}, 1'b1}, lo: '0, hi: IdxMax, comb: 1'b0};
              state_q <= StRd;
            end
          end
        end
        StPop: begin
          if (sp_q == '0) begin
            state_q <= (op_q == OpAdd) ? StIdle : StOut;
          end else begin
            cur_q <= stk_q[sp_dec[SI-1:0]];
            sp_q <= sp_dec;
            state_q <= StRd;
          end
        end
        StRd: state_q <= StVisit;
        StVisit: begin
          if (cur_q.comb) begin
            lmin_q <= rmin;
            lmax_q <= rmax;
            state_q <= StComb;
          end else if (full) begin
            if (op_q != OpAdd) begin
              if (rmin < mn_q) mn_q <= rmin;
              if (rmax > mx_q) mx_q <= rmax;
            end
            state_q <= StPop;
          end else begin
            npend_q <= rpend;
            if (op_q == OpAdd) begin
              stk_q[sp_q[SI-1:0]] <= '{node: cur_q.node, lo: cur_q.lo, hi: cur_q.hi,
                                       comb: 1'b1};
              sp_q <= sp_q + 1'b1;
            end
            state_q <= StLeft;
          end
        end
        StLeft: state_q <= StRight;
        StRight: begin
          if (go_l && go_r) begin
            stk_q[sp_q[SI-1:0]] <= '{node: rch, lo: mid + 1'b1, hi: cur_q.hi, comb: 1'b0};
            sp_q <= sp_q + 1'b1;
            cur_q <= '{node: lch, lo: cur_q.lo, hi: mid, comb: 1'b0};
          end else if (go_l) begin
            cur_q <= '{node: lch, lo: cur_q.lo, hi: mid, comb: 1'b0};
          end else begin
            cur_q <= '{node: rch, lo: mid + 1'b1, hi: cur_q.hi, comb: 1'b0};
          end
          state_q <= StRd;
        end
        StComb: state_q <= StPop;
        StOut: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q));
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready);
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SB'(SD));
endmodule

>>> sim/tb.sv
// Testbench for the lazy range add min/max tree: directed table plus random traffic.
`timescale 1ns / 100ps

module tb;
  import lrt_pkg::*;

  localparam int Leaves = 1024;
  localparam int DataW = 56;
  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 600;

  typedef struct packed {
    logic signed [47:0] ans;
    logic               emp;
  } answer_t;

  typedef struct {
    logic [1:0]         op;
    int                 lo;
    int                 hi;
    logic signed [31:0] delta;
    bit                 typed;
    logic signed [47:0] want_ans;
    logic               want_emp;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  lazy_range_add_min_max_tree DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  val_t    tree_min [2*Leaves];
  val_t    tree_max [2*Leaves];
  val_t    tree_pend[2*Leaves];
  int      last_idx = 1023;
  answer_t pending_answers[$];
  int      mismatches = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      quiet_cycles = 0;

  function automatic val_t clamp48(longint v);
    if (v > longint'(VMax)) return VMax;
    if (v < longint'(VMin)) return VMin;
    return val_t'(v);
  endfunction

  function automatic void node_add(int n, val_t d);
    tree_min[n] = clamp48(longint'(tree_min[n]) + longint'(d));
    tree_max[n] = clamp48(longint'(tree_max[n]) + longint'(d));
    if (n < Leaves) tree_pend[n] = clamp48(longint'(tree_pend[n]) + longint'(d));
  endfunction

  function automatic void node_push(int n);
    if (n < Leaves && tree_pend[n] != 0) begin
      node_add(2*n, tree_pend[n]);
      node_add(2*n+1, tree_pend[n]);
      tree_pend[n] = 0;
    end
  endfunction

  function automatic void tree_range_add(int s, int e, val_t d);
    int stn[64], stl[64], sth[64];
    bit stp[64];
    int sp, n, lo, hi, mid;
    stn[0] = 1; stl[0] = 0; sth[0] = Leaves-1; stp[0] = 0; sp = 1;
    while (sp > 0) begin
      n = stn[sp-1]; lo = stl[sp-1]; hi = sth[sp-1];
      if (stp[sp-1]) begin
        tree_min[n] = tree_min[2*n] < tree_min[2*n+1] ? tree_min[2*n] : tree_min[2*n+1];
        tree_max[n] = tree_max[2*n] > tree_max[2*n+1] ? tree_max[2*n] : tree_max[2*n+1];
        sp--;
      end else if (e < lo || s > hi) begin
        sp--;
      end else if (s <= lo && hi <= e) begin
        node_add(n, d);
        sp--;
      end else begin
        node_push(n);
        mid = lo + (hi - lo) / 2;
        stp[sp-1] = 1;
        stn[sp] = 2*n+1; stl[sp] = mid+1; sth[sp] = hi; stp[sp] = 0; sp++;
        stn[sp] = 2*n; stl[sp] = lo; sth[sp] = mid; stp[sp] = 0; sp++;
      end
    end
  endfunction

  function automatic void tree_range_query(int s, int e, output val_t mn, output val_t mx);
    int stn[64], stl[64], sth[64];
    int sp, n, lo, hi, mid;
    mn = VMax; mx = VMin;
    stn[0] = 1; stl[0] = 0; sth[0] = Leaves-1; sp = 1;
    while (sp > 0) begin
      sp--;
      n = stn[sp]; lo = stl[sp]; hi = sth[sp];
      if (s <= lo && hi <= e) begin
        if (tree_min[n] < mn) mn = tree_min[n];
        if (tree_max[n] > mx) mx = tree_max[n];
      end else begin
        node_push(n);
        mid = lo + (hi - lo) / 2;
        if (s <= mid) begin
          stn[sp] = 2*n; stl[sp] = lo; sth[sp] = mid; sp++;
        end
        if (e > mid) begin
          stn[sp] = 2*n+1; stl[sp] = mid+1; sth[sp] = hi; sp++;
        end
      end
    end
  endfunction

  // returns 1 when the item yields a result
  function automatic bit tree_predict(logic [1:0] op, int s, int e, logic signed [31:0] d,
                                      output answer_t res);
    int   top;
    val_t mn, mx;
    longint diff;
    top = last_idx < Leaves-1 ? last_idx : Leaves-1;
    if (e > top) e = top;
    res = '0;
    if (op == OpAdd) begin
      if (s <= e) tree_range_add(s, e, val_t'(d));
      return 0;
    end
    if (s > e) begin
      res.emp = 1'b1;
      return 1;
    end
    tree_range_query(s, e, mn, mx);
    case (op)
      OpMin: res.ans = mn;
      OpMax: res.ans = mx;
      default: begin
        diff = longint'(mx) - longint'(mn);
        res.ans = clamp48(diff);
      end
    endcase
    return 1;
  endfunction

  initial begin
    for (int i = 0; i < 2*Leaves; i++) begin
      tree_min[i] = 0; tree_max[i] = 0; tree_pend[i] = 0;
    end
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ans = m_axis_tdata;
      got.emp = m_axis_tuser;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: answer %0d empty %0b", got.ans, got.emp);
      end else begin
        want = pending_answers.pop_front();
        if (got.ans !== want.ans || got.emp !== want.emp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected answer %0d empty %0b, got answer %0d empty %0b",
                     want.ans, want.emp, got.ans, got.emp);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic cfg_write(int value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegLastIndex; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    last_idx = value & 32'h3FF;
  endtask

  task automatic wait_idle();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // drives one transfer; when typed, the given answer replaces the predicted one
  task automatic send_item(logic [1:0] op, int s, int e, logic signed [31:0] d,
                           bit typed, answer_t typed_res);
    answer_t res;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, d, e[9:0], s[9:0], op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (tree_predict(op, s, e, d, res)) pending_answers.push_back(typed ? typed_res : res);
  endtask

  task automatic random_item();
    logic [1:0] op;
    int s, e, w;
    logic signed [31:0] d;
    op = $urandom_range(3);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        s = $urandom_range(Leaves-1);
        w = $urandom_range(15);
        e = (s + w > Leaves-1) ? Leaves-1 : s + w;
      end
      5, 6, 7: begin
        s = $urandom_range(Leaves-1);
        e = $urandom_range(Leaves-1);
      end
      8: begin
        s = $urandom_range(1) ? 0 : $urandom_range(3);
        e = $urandom_range(1) ? Leaves-1 : Leaves-1-$urandom_range(3);
      end
      default: begin
        e = $urandom_range(Leaves-2);
        s = e + 1 + $urandom_range(Leaves-2-e);
      end
    endcase
    case ($urandom_range(3))
      0: d = $signed($urandom_range(200)) - 100;
      1: d = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: d = $urandom;
    endcase
    send_item(op, s, e, d, 1'b0, '0);
  endtask

  row_t directed[$] = '{
    '{OpMin, 0, 1023, 0, 1, 0, 0},
    '{OpMax, 0, 1023, 0, 1, 0, 0},
    '{OpSpread, 0, 1023, 0, 1, 0, 0},
    '{OpMin, 5, 3, 0, 1, 0, 1},
    '{OpSpread, 1023, 0, 0, 1, 0, 1},
    '{OpAdd, 9, 2, 32'sh7FFFFFFF, 0, 0, 0},
    '{OpMax, 0, 1023, 0, 1, 0, 0},
    '{OpAdd, 0, 1023, 32'sh7FFFFFFF, 0, 0, 0},
    '{OpMax, 0, 1023, 0, 1, 48'sh7FFFFFFF, 0},
    '{OpAdd, 0, 0, 32'sh80000000, 0, 0, 0},
    '{OpMin, 0, 0, 0, 1, -1, 0},
    '{OpSpread, 0, 1023, 0, 0, 0, 0},
    '{OpAdd, 1023, 1023, -5, 0, 0, 0},
    '{OpMin, 1000, 1023, 0, 0, 0, 0},
    '{OpMax, 1023, 1023, 0, 0, 0, 0},
    '{OpAdd, 100, 700, 32'sh80000000, 0, 0, 0},
    '{OpAdd, 300, 301, 12345, 0, 0, 0},
    '{OpMin, 0, 1023, 0, 0, 0, 0},
    '{OpMax, 250, 650, 0, 0, 0, 0},
    '{OpSpread, 200, 800, 0, 0, 0, 0},
    '{OpSpread, 301, 301, 0, 0, 0, 0},
    '{OpAdd, 512, 511, 7, 0, 0, 0},
    '{OpMin, 511, 512, 0, 0, 0, 0}
  };

  int phase_last[6]  = '{1023, 0, 300, 511, 1022, 1023};
  int phase_idle[6]  = '{0, 75, 0, 24, 0, 75};
  int phase_stall[6] = '{0, 0, 75, 24, 0, 0};

  initial begin
    answer_t tr;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      tr.ans = directed[i].want_ans;
      tr.emp = directed[i].want_emp;
      send_item(directed[i].op, directed[i].lo, directed[i].hi, directed[i].delta,
                directed[i].typed, tr);
    end
    for (int p = 0; p < 6; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      send_idle = phase_idle[p];
      recv_stall = phase_stall[p];
      cfg_write(p == 2 ? $urandom_range(1, 1022) : phase_last[p]);
      for (int k = 0; k < 280; k++) random_item();
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
